>>> rtl/bs3_pkg.sv
`timescale 1ns / 1ps

package bs3_pkg;

  // Width of the image size register and of the padded row and column counters.
  localparam int SIZE_W = 6;

  // Image size after reset.
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 6'd28;

  // Register index of the image size register in the configuration space.
  localparam logic REG_IMAGE_SIZE = 1'b0;

  // Result queue geometry.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_LVL_W = 3;

  // Frame settings that the configuration block hands to the window engine.
  typedef struct packed {
    logic [SIZE_W-1:0] n;        // effective image size
    logic [SIZE_W-1:0] w_last;   // last padded row and column, n + 1
    logic              restart;  // size write, return to the frame origin
  } frame_cfg_t;

  // Clamp a written size into 1 .. hi.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] sz,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = sz;
    if (sz == '0) begin
      res = SIZE_W'(1);
    end else if (sz > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage

>>> rtl/bs3_front.sv
`timescale 1ns / 1ps

module bs3_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [DATA_WIDTH-1:0] in_pixel,
  output logic                  pix_valid,
  output logic [DATA_WIDTH-1:0] pix_data,
  input  logic                  pix_take
);
  import bs3_pkg::*;

  logic [DATA_WIDTH-1:0] slot_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  // Transfer handshakes on both sides of the pixel queue.
  assign full      = (count_r == 2'd2);
  assign do_push   = push && !full;
  assign pix_valid = (count_r != 2'd0);
  assign do_pop    = pix_take && pix_valid;
  assign pix_data  = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Pixel storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_pixel;
    end
  end

endmodule

>>> rtl/bs3_back.sv
`timescale 1ns / 1ps

module bs3_back #(
  parameter int LINE_DEPTH = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bs3_pkg::frame_cfg_t             cfg,
  input  logic                            pix_valid,
  input  logic [DATA_WIDTH-1:0]           pix_data,
  output logic                            pix_take,
  input  logic [bs3_pkg::RES_LVL_W-1:0]   res_level,
  output logic                            res_push,
  output logic [DATA_WIDTH-1:0]           res_sum,
  output logic                            res_last
);
  import bs3_pkg::*;

  localparam int COL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Padded raster position of the next visit.
  logic [SIZE_W-1:0]     row_r, row_nxt;
  logic [SIZE_W-1:0]     col_r, col_nxt;
  logic                  interior;
  logic                  at_last_col;
  logic                  room;
  logic                  fire;
  logic [RES_LVL_W-1:0]  used;

  // Line stores: two padded rows above the current one.
  logic [DATA_WIDTH-1:0] upper_mem [LINE_DEPTH];
  logic [DATA_WIDTH-1:0] lower_mem [LINE_DEPTH];
  logic [DATA_WIDTH-1:0] up_rd_r;
  logic [DATA_WIDTH-1:0] lo_rd_r;

  // Second stage: line store update and column sum.
  logic                  b_valid_r;
  logic [COL_W-1:0]      b_col_r;
  logic [DATA_WIDTH-1:0] b_pix_r;
  logic                  b_due_r;
  logic                  b_last_r;
  logic [DATA_WIDTH-1:0] col_sum;

  // Window held as three column sums, oldest first.
  logic [DATA_WIDTH-1:0] cs_r [3];

  // Third stage: window sum into the result queue.
  logic                  c_push_r;
  logic                  c_last_r;

  // Classify the current position and decide whether it can be visited.
  assign interior    = (row_r != '0) && (row_r <= cfg.n) &&
                       (col_r != '0) && (col_r <= cfg.n);
  assign at_last_col = (col_r == cfg.w_last);
  assign used        = res_level + RES_LVL_W'(b_valid_r) + RES_LVL_W'(c_push_r);
  assign room        = (used < RES_LVL_W'(RES_DEPTH));
  assign fire        = room && !cfg.restart && (!interior || pix_valid);
  assign pix_take    = fire && interior;

  // Walk the padded raster one position per visit.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg.restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (fire) begin
      if (at_last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == cfg.w_last) ? '0 : row_r + SIZE_W'(1);
      end else begin
        col_nxt = col_r + SIZE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
      c_push_r  <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      b_valid_r <= fire;
      c_push_r  <= b_valid_r && b_due_r;
    end
  end

  // Line store read on a visit, write back in the following cycle.
  always_ff @(posedge clk) begin
    if (fire) begin
      up_rd_r <= upper_mem[col_r[COL_W-1:0]];
      lo_rd_r <= lower_mem[col_r[COL_W-1:0]];
    end
    if (b_valid_r) begin
      upper_mem[b_col_r] <= lo_rd_r;
      lower_mem[b_col_r] <= b_pix_r;
    end
  end

  // Second stage payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      b_col_r  <= col_r[COL_W-1:0];
      b_pix_r  <= interior ? pix_data : '0;
      b_due_r  <= (row_r >= SIZE_W'(2)) && (col_r >= SIZE_W'(2));
      b_last_r <= (row_r == cfg.w_last) && at_last_col;
    end
  end

  // Shift the new column into the window.
  assign col_sum = up_rd_r + lo_rd_r + b_pix_r;

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      cs_r[0]  <= cs_r[1];
      cs_r[1]  <= cs_r[2];
      cs_r[2]  <= col_sum;
      c_last_r <= b_last_r;
    end
  end

  // Window sum toward the result queue.
  assign res_push = c_push_r;
  assign res_sum  = cs_r[0] + cs_r[1] + cs_r[2];
  assign res_last = c_last_r;

endmodule

>>> rtl/bs3_res_fifo.sv
`timescale 1ns / 1ps

module bs3_res_fifo #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_push,
  input  logic [DATA_WIDTH-1:0]         res_sum,
  input  logic                          res_last,
  output logic [bs3_pkg::RES_LVL_W-1:0] res_level,
  output logic                          empty,
  input  logic                          pop,
  output logic [DATA_WIDTH-1:0]         out_window_sum,
  output logic                          out_frame_end
);
  import bs3_pkg::*;

  logic [DATA_WIDTH-1:0] sum_r  [RES_DEPTH];
  logic                  last_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [RES_LVL_W-1:0]  level_r, level_nxt;
  logic                  do_pop;

  // Head of the queue drives the result ports.
  assign empty          = (level_r == '0);
  assign do_pop         = pop && !empty;
  assign res_level      = level_r;
  assign out_window_sum = sum_r[rd_ptr_r];
  assign out_frame_end  = last_r[rd_ptr_r];

  // Pointer and level update; the engine never pushes into a full queue.
  always_comb begin
    wr_ptr_nxt = res_push ? wr_ptr_r + RES_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + RES_PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r;
    if (res_push && !do_pop) begin
      level_nxt = level_r + RES_LVL_W'(1);
    end else if (do_pop && !res_push) begin
      level_nxt = level_r - RES_LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      sum_r[wr_ptr_r]  <= res_sum;
      last_r[wr_ptr_r] <= res_last;
    end
  end

endmodule

>>> rtl/box_sum_3x3_line_buffer_core.sv
`timescale 1ns / 1ps
// Channel    Direction  Ports                                 Transfer when
// input      in         push, full, in_pixel                  push && !full
// result     out        empty, pop, out_window_sum,           pop && !empty
//                       out_frame_end
// config     in/out     psel, penable, pwrite, paddr,         psel && penable && pwrite
//                       pwdata, prdata, pready
//
// The window engine visits one padded position per cycle while the result queue
// has room, no size write is under way and any pixel it needs is queued; an N x N
// image takes (N+2)*(N+2) visits; a visit's result passes the second and third stages.
// Reset is synchronous; no clearing pass is needed, the line stores are rewritten
// by the first two padded rows of every frame before they feed a sum.
// The engine stalls once queued and in-flight results would fill the result queue, and
// the pixel queue keeps accepting until it fills.

module box_sum_3x3_line_buffer_core #(
  parameter int LINE_DEPTH = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  push,
  output logic                  full,
  input  logic [DATA_WIDTH-1:0] in_pixel,
  // Result channel
  output logic                  empty,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] out_window_sum,
  output logic                  out_frame_end,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import bs3_pkg::*;

  logic [SIZE_W-1:0]     image_size_r;
  logic [SIZE_W-1:0]     n_r;
  logic [SIZE_W-1:0]     w_last_r;
  logic [SIZE_W-1:0]     size_hi;
  logic [SIZE_W-1:0]     n_wr;
  logic [SIZE_W-1:0]     n_rst;
  logic                  size_wr;
  frame_cfg_t            frame_cfg;

  logic                  pix_valid;
  logic [DATA_WIDTH-1:0] pix_data;
  logic                  pix_take;
  logic [RES_LVL_W-1:0]  res_level;
  logic                  res_push;
  logic [DATA_WIDTH-1:0] res_sum;
  logic                  res_last;

  // Configuration register decode.
  assign pready  = 1'b1;
  assign size_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_SIZE);
  assign size_hi = SIZE_W'(LINE_DEPTH - 2);
  assign n_wr    = clamp_size(pwdata[SIZE_W-1:0], size_hi);
  assign n_rst   = clamp_size(IMAGE_SIZE_RESET, size_hi);
  assign prdata  = (paddr[2] == REG_IMAGE_SIZE) ? 32'(image_size_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= IMAGE_SIZE_RESET;
      n_r          <= n_rst;
      w_last_r     <= n_rst + SIZE_W'(1);
    end else if (size_wr) begin
      image_size_r <= pwdata[SIZE_W-1:0];
      n_r          <= n_wr;
      w_last_r     <= n_wr + SIZE_W'(1);
    end
  end

  assign frame_cfg.n       = n_r;
  assign frame_cfg.w_last  = w_last_r;
  assign frame_cfg.restart = size_wr;

  // Pixel queue in front of the window engine.
  bs3_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_pixel  (in_pixel),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_take  (pix_take)
  );

  // Raster walker, line stores and window sum.
  bs3_back #(
    .LINE_DEPTH(LINE_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (frame_cfg),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .pix_take  (pix_take),
    .res_level (res_level),
    .res_push  (res_push),
    .res_sum   (res_sum),
    .res_last  (res_last)
  );

  // Result queue toward the consumer.
  bs3_res_fifo #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_res_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_push       (res_push),
    .res_sum        (res_sum),
    .res_last       (res_last),
    .res_level      (res_level),
    .empty          (empty),
    .pop            (pop),
    .out_window_sum (out_window_sum),
    .out_frame_end  (out_frame_end)
  );

`ifndef SYNTH
  // The engine only takes a pixel that the front queue holds.
  a_take_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    pix_take |-> pix_valid)
    else $error("engine took a pixel from an empty queue");

  // Credit accounting keeps the result queue from overflowing.
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_level < RES_LVL_W'(RES_DEPTH)) || (pop && !empty))
    else $error("result pushed into a full queue");

  // A size write never consumes a pixel in the same cycle.
  a_restart_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    size_wr |-> !pix_take)
    else $error("pixel consumed during a frame restart");
`endif

endmodule
